// ===== rtl/ts_packet_pid_pcr_monitor_assert.svh =====
// Assertion macros for the transport stream PID / PCR monitor.
// Both macros expect clk_i and rst_ni in scope at the place of use.
`ifndef TS_PACKET_PID_PCR_MONITOR_ASSERT_SVH
`define TS_PACKET_PID_PCR_MONITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ts monitor: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TSPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ts monitor: next-cycle check failed");

`endif

// ===== rtl/tspm_pkg.sv =====
package tspm_pkg;

  localparam int unsigned PID_W      = 13;
  localparam int unsigned NUM_PIDS   = 8192;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [7:0] PKT_LEN   = 8'd188;
  localparam logic [7:0] SYNC_BYTE = 8'h47;
  localparam logic [7:0] MARK_NEW  = 8'hDF;
  localparam logic [7:0] MARK_OLD  = 8'hA9;

  // Register byte addresses on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_CHECK_SYNC = 3'd0;

  // Operation codes of an input word.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Kinds of encoder boundary point marker.
  localparam logic [1:0] EBP_NONE = 2'd0;
  localparam logic [1:0] EBP_NEW  = 2'd1;
  localparam logic [1:0] EBP_OLD  = 2'd2;

  typedef struct packed {
    logic             op;
    logic [7:0]       data_byte;
    logic             packet_start;
    logic [63:0]      arrival_time;
    logic [PID_W-1:0] query_pid;
  } tspm_in_t;

  typedef struct packed {
    logic             is_query;
    logic             sync_error;
    logic [PID_W-1:0] pid;
    logic [31:0]      pid_count;
    logic             has_pcr;
    logic [32:0]      pcr_base;
    logic [63:0]      report_time;
    logic [1:0]       ebp_kind;
    logic [31:0]      ebp_seconds;
  } tspm_out_t;

  // Work held between the histogram read and its write back.
  typedef struct packed {
    logic             is_query;
    logic             sync_error;
    logic             upd;
    logic [PID_W-1:0] pid;
    logic             has_pcr;
    logic [32:0]      pcr_base;
    logic [63:0]      report_time;
    logic [1:0]       ebp_kind;
    logic [31:0]      ebp_seconds;
  } tspm_s1_t;

endpackage

// ===== rtl/ts_packet_pid_pcr_monitor.sv =====
// A result word is registered in stage 1, then in the output register, before it leaves.
// Throughput: one input word per cycle when the input is not stalled; the per-PID histogram
// memory does one read and one write per cycle, and a packet needs only one read-modify-write
// per 188 bytes. Reset: control state clears at once, then a sweep zeroes all 8192 histogram
// entries, one per cycle, and the input stays stalled until the sweep ends.
module ts_packet_pid_pcr_monitor #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tspm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tspm_pkg::tspm_in_t               in_word_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tspm_pkg::tspm_out_t              out_word_o
);
  import tspm_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register. The sync check is sampled on byte 0 of each packet.
  // ---------------------------------------------------------------------------
  logic check_sync_q;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_CHECK_SYNC) ? {31'd0, check_sync_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_sync_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr == REG_CHECK_SYNC)) begin
      check_sync_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Histogram clearing sweep after reset. While it runs no word is accepted.
  // ---------------------------------------------------------------------------
  logic             clr_busy_q;
  logic [PID_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + PID_W'(1);
      if (clr_addr_q == PID_W'(NUM_PIDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes. Stage 1 holds one word between the memory read and the write
  // back; the output register sits behind it, so a new word is taken while a
  // finished result still waits downstream.
  // ---------------------------------------------------------------------------
  tspm_s1_t  s1_q, s1_d;
  logic      s1_vld_q;
  logic      s1_adv;
  logic      in_acc;
  logic      out_vld_q;
  tspm_out_t out_q, out_d;

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = clr_busy_q || (s1_vld_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Packet parser. The byte index is the position within the current packet;
  // zero means that no packet is open and stray bytes are ignored. A packet
  // start in the middle of a packet drops the partial packet.
  // ---------------------------------------------------------------------------
  logic [7:0]       pos_q, pos_d;
  logic             sync_bad_q, sync_bad_d;
  logic [PID_W-1:0] pid_q, pid_d;
  logic [15:0]      flags_q, flags_d;
  logic [32:0]      pcr_q, pcr_d;
  logic [7:0]       marker_q, marker_d;
  logic [31:0]      ebp_q, ebp_d;
  logic [63:0]      time_q, time_d;

  logic       is_byte;
  logic       pkt_active;
  logic [7:0] idx;
  logic [7:0] idx_next;
  logic       pkt_last;
  logic [7:0] b;

  assign b          = in_word_i.data_byte;
  assign is_byte    = in_acc && (in_word_i.op == OP_BYTE);
  assign pkt_active = in_word_i.packet_start || (pos_q != 8'd0);
  assign idx        = in_word_i.packet_start ? 8'd0 : pos_q;
  assign idx_next   = idx + 8'd1;
  assign pkt_last   = is_byte && pkt_active && (idx_next == PKT_LEN);

  always_comb begin
    pos_d      = pos_q;
    sync_bad_d = sync_bad_q;
    pid_d      = pid_q;
    flags_d    = flags_q;
    pcr_d      = pcr_q;
    marker_d   = marker_q;
    ebp_d      = ebp_q;
    time_d     = time_q;
    if (is_byte && pkt_active) begin
      if (in_word_i.packet_start) begin
        time_d     = in_word_i.arrival_time;
        sync_bad_d = 1'b0;
        pid_d      = '0;
        flags_d    = '0;
        pcr_d      = '0;
        marker_d   = '0;
        ebp_d      = '0;
      end
      pos_d = pkt_last ? 8'd0 : idx_next;
      if (idx == 8'd0) begin
        sync_bad_d = check_sync_q && (b != SYNC_BYTE);
      end else if (idx == 8'd1) begin
        pid_d = {b[4:0], 8'd0};
      end else if (idx == 8'd2) begin
        pid_d = {pid_q[PID_W-1:8], b};
      end else if (idx == 8'd3) begin
        flags_d = {b, 8'd0};
      end else if (idx == 8'd4) begin
        flags_d = {flags_q[15:8], b};
      end else if (idx == 8'd5) begin
        // Adaptation flags count only when the adaptation length is not zero.
        flags_d = {flags_q[15:8], (flags_q[7:0] != 8'd0) ? b : 8'd0};
      end else if (idx >= 8'd6 && idx <= 8'd9) begin
        pcr_d = {pcr_q[24:0], b};
      end else if (idx == 8'd10) begin
        pcr_d = {pcr_q[31:0], b[7]};
      end else if (idx == 8'd13) begin
        marker_d = b;
      end else if (idx >= 8'd16 && idx <= 8'd19) begin
        if (marker_q == MARK_OLD) begin
          ebp_d = {ebp_q[23:0], b};
        end
      end else if (idx >= 8'd20 && idx <= 8'd23) begin
        if (marker_q == MARK_NEW) begin
          ebp_d = {ebp_q[23:0], b};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 8'd0;
      sync_bad_q <= 1'b0;
      pid_q      <= '0;
      flags_q    <= '0;
      pcr_q      <= '0;
      marker_q   <= '0;
      ebp_q      <= '0;
      time_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      sync_bad_q <= sync_bad_d;
      pid_q      <= pid_d;
      flags_q    <= flags_d;
      pcr_q      <= pcr_d;
      marker_q   <= marker_d;
      ebp_q      <= ebp_d;
      time_q     <= time_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 load. The last byte of a packet changes no parser field but the byte
  // index, so the report is built from the parser registers as they stand. A query or a
  // packet with good sync reads its histogram entry in the same cycle.
  // ---------------------------------------------------------------------------
  logic             is_query_acc;
  logic             s1_load;
  logic             adapt;
  logic             rd_en;
  logic [PID_W-1:0] rd_addr;

  assign is_query_acc = in_acc && (in_word_i.op == OP_QUERY);
  assign s1_load      = is_query_acc || pkt_last;
  assign adapt        = flags_q[13];
  assign rd_en        = is_query_acc || (pkt_last && !sync_bad_q);
  assign rd_addr      = is_query_acc ? in_word_i.query_pid : pid_q;

  always_comb begin
    s1_d = '0;
    if (is_query_acc) begin
      s1_d.is_query = 1'b1;
      s1_d.pid      = in_word_i.query_pid;
    end else begin
      s1_d.report_time = time_q;
      if (sync_bad_q) begin
        s1_d.sync_error = 1'b1;
      end else begin
        s1_d.upd      = 1'b1;
        s1_d.pid      = pid_q;
        s1_d.has_pcr  = adapt && flags_q[4];
        s1_d.pcr_base = (adapt && flags_q[4]) ? pcr_q : 33'd0;
        if (adapt && flags_q[1] && marker_q == MARK_NEW) begin
          s1_d.ebp_kind    = EBP_NEW;
          s1_d.ebp_seconds = ebp_q;
        end else if (adapt && flags_q[1] && marker_q == MARK_OLD) begin
          s1_d.ebp_kind    = EBP_OLD;
          s1_d.ebp_seconds = ebp_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= s1_load;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s1_load) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Histogram memory: one write port, one registered read port. A read in the
  // same cycle as a write to the same entry returns the old value, so the most
  // recent write is kept aside and forwarded on an address match.
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] hist_mem [NUM_PIDS];
  logic [COUNT_BITS-1:0] rd_q;
  logic                  last_wr_vld_q;
  logic [PID_W-1:0]      last_wr_addr_q;
  logic [COUNT_BITS-1:0] last_wr_data_q;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic                  wr_en;
  logic [PID_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  assign cur_cnt = (last_wr_vld_q && last_wr_addr_q == s1_q.pid) ? last_wr_data_q : rd_q;
  assign inc_cnt = cur_cnt + COUNT_BITS'(1);
  assign wr_en   = clr_busy_q || (s1_adv && s1_q.upd);
  assign wr_addr = clr_busy_q ? clr_addr_q : s1_q.pid;
  assign wr_data = clr_busy_q ? '0 : inc_cnt;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_wr_vld_q <= 1'b0;
    end else if (s1_adv && s1_q.upd) begin
      last_wr_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.upd) begin
      last_wr_addr_q <= s1_q.pid;
      last_wr_data_q <= inc_cnt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_d             = '0;
    out_d.is_query    = s1_q.is_query;
    out_d.sync_error  = s1_q.sync_error;
    out_d.pid         = s1_q.pid;
    out_d.has_pcr     = s1_q.has_pcr;
    out_d.pcr_base    = s1_q.pcr_base;
    out_d.report_time = s1_q.report_time;
    out_d.ebp_kind    = s1_q.ebp_kind;
    out_d.ebp_seconds = s1_q.ebp_seconds;
    if (s1_q.is_query) begin
      out_d.pid_count = 32'(cur_cnt);
    end else if (s1_q.upd) begin
      out_d.pid_count = 32'(inc_cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `include "ts_packet_pid_pcr_monitor_assert.svh"

  `TSPM_ASSERT_NOW(a_no_work_in_clear, clr_busy_q, !s1_vld_q && !out_vld_q)
  `TSPM_ASSERT_NOW(a_pos_in_range, 1'b1, pos_q < PKT_LEN)
  `TSPM_ASSERT_NOW(a_hold_stalls_input, s1_vld_q && !s1_adv, in_stall_o)
  `TSPM_ASSERT_NEXT(a_fwd_tracks_write, s1_adv && s1_q.upd,
                    last_wr_vld_q && last_wr_addr_q == $past(s1_q.pid))

endmodule
